>>> src/cc20_pkg.sv
// ----------------------------------------------------------------------------
// cc20_pkg
// Shared types, constants and helper functions for the ChaCha20 stream cipher.
// ----------------------------------------------------------------------------
package cc20_pkg;

  localparam int WORD_W        = 32;
  localparam int BLK_WORDS     = 16;
  localparam int BLK_BYTES     = 64;
  localparam int POS_W         = $clog2(BLK_BYTES);
  localparam int WIDX_W        = $clog2(BLK_WORDS);
  localparam int DOUBLE_ROUNDS = 10;
  // One double round is eight quarter rounds of four steps each.
  localparam int STEPS_PER_DR  = 32;
  localparam int ROUND_STEPS   = DOUBLE_ROUNDS * STEPS_PER_DR;
  localparam int STEP_W        = $clog2(ROUND_STEPS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ROUND_STEPS - 1);
  localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(BLK_WORDS - 1);
  localparam logic [POS_W-1:0]  LAST_POS  = POS_W'(BLK_BYTES - 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // The four "expand 32-byte k" words, word 0 in the lowest slot.
  localparam logic [3:0][WORD_W-1:0] SIGMA = {
    32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865
  };

  typedef logic [BLK_WORDS-1:0][WORD_W-1:0] blk_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY0     = 3'd0,
    REG_KEY1     = 3'd1,
    REG_KEY2     = 3'd2,
    REG_KEY3     = 3'd3,
    REG_NONCE_LO = 3'd4,
    REG_NONCE_HI = 3'd5
  } cfg_reg_t;

  // Key and nonce as 32-bit little-endian words.
  typedef struct packed {
    logic [7:0][WORD_W-1:0] key;
    logic [2:0][WORD_W-1:0] nonce;
  } cc20_cfg_t;

  // Request from the byte controller to the block core.
  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] counter;
  } core_req_t;

  // Status from the block core.
  typedef struct packed {
    logic       busy;
    logic       done;
    logic [7:0] ks_byte;
  } core_sts_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_WAIT,
    ST_EMIT
  } top_state_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_ROUND,
    CS_FINAL
  } core_state_t;

  // Word idx of the initial block state.
  function automatic logic [WORD_W-1:0] init_word(input cc20_cfg_t cfg,
                                                  input logic [WORD_W-1:0] ctr,
                                                  input logic [WIDX_W-1:0] idx);
    logic [WORD_W-1:0] w;
    if (idx < 4'd4) begin
      w = SIGMA[idx[1:0]];
    end else if (idx < 4'd12) begin
      w = cfg.key[3'(idx - 4'd4)];
    end else if (idx == 4'd12) begin
      w = ctr;
    end else begin
      w = cfg.nonce[2'(idx - 4'd13)];
    end
    return w;
  endfunction

  // Rotation that closes each step of a quarter round.
  function automatic logic [WORD_W-1:0] step_rot(input logic [WORD_W-1:0] v,
                                                 input logic [1:0] sub);
    logic [WORD_W-1:0] r;
    case (sub)
      2'd0:    r = {v[15:0], v[31:16]};
      2'd1:    r = {v[19:0], v[31:20]};
      2'd2:    r = {v[23:0], v[31:24]};
      2'd3:    r = {v[24:0], v[31:25]};
      default: r = v;
    endcase
    return r;
  endfunction

  // Word rotation applied to row r at the end of quarter round qr. The last
  // column round also skews the rows onto the diagonals, and the last diagonal
  // round undoes the skew.
  function automatic logic [1:0] row_rot(input logic [2:0] qr, input logic [1:0] r);
    logic [1:0] k;
    if (qr == 3'd3) begin
      k = 2'd1 + r;
    end else if (qr == 3'd7) begin
      k = 2'd1 - r;
    end else begin
      k = 2'd1;
    end
    return k;
  endfunction

endpackage

>>> src/cc20_in_if.sv
// ----------------------------------------------------------------------------
// cc20_in_if
// Input channel: one data byte and a message-start flag per beat.
// ----------------------------------------------------------------------------
interface cc20_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       msg_start;

  modport source (output valid, output in_byte, output msg_start, input ready);
  modport sink (input valid, input in_byte, input msg_start, output ready);
endinterface

>>> src/cc20_out_if.sv
// ----------------------------------------------------------------------------
// cc20_out_if
// Result channel: one enciphered or deciphered byte per beat.
// ----------------------------------------------------------------------------
interface cc20_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;

  modport source (output valid, output out_byte, input ready);
  modport sink (input valid, input out_byte, output ready);
endinterface

>>> src/cc20_core.sv
// ----------------------------------------------------------------------------
// cc20_core
// Keystream block generator: one shared add-xor-rotate unit steps through the
// 20 rounds, then a final pass adds the initial state word by word.
// ----------------------------------------------------------------------------
module cc20_core import cc20_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cc20_cfg_t cfg,
  input  core_req_t req,
  input  logic [POS_W-1:0] byte_sel,
  output core_sts_t sts
);

  core_state_t       phase_r, phase_nxt;
  blk_t              w_r, w_nxt;
  logic [WORD_W-1:0] ctr_r;
  logic [STEP_W-1:0] step_r;
  logic [WIDX_W-1:0] fin_r;

  logic [1:0]        sub;
  logic [2:0]        qr;
  logic [WORD_W-1:0] x_w, y_w, z_w, sum, mixed;
  blk_t              upd, perm;
  logic [WORD_W-1:0] ks_word;

  assign sub = step_r[1:0];
  assign qr  = step_r[4:2];

  // Shared unit. The quarter round always works on words 0, 4, 8 and 12;
  // even steps do a += b, d ^= a, odd steps do c += d, b ^= c.
  always_comb begin
    x_w   = sub[0] ? w_r[8]  : w_r[0];
    y_w   = sub[0] ? w_r[12] : w_r[4];
    z_w   = sub[0] ? w_r[4]  : w_r[12];
    sum   = x_w + y_w;
    mixed = step_rot(z_w ^ sum, sub);
  end

  // Write back, then rotate each row so the next column or diagonal lands
  // on the fixed positions.
  always_comb begin
    logic [1:0] k;
    logic [1:0] sel;
    upd = w_r;
    if (sub[0]) begin
      upd[8] = sum;
      upd[4] = mixed;
    end else begin
      upd[0]  = sum;
      upd[12] = mixed;
    end
    for (int r = 0; r < 4; r++) begin
      k = row_rot(qr, 2'(r));
      for (int j = 0; j < 4; j++) begin
        sel = 2'(j) + k;
        perm[r*4 + j] = upd[{2'(r), sel}];
      end
    end
  end

  // Working state update.
  always_comb begin
    w_nxt = w_r;
    case (phase_r)
      CS_IDLE: begin
        if (req.start) begin
          for (int i = 0; i < BLK_WORDS; i++) begin
            w_nxt[i] = init_word(cfg, req.counter, WIDX_W'(i));
          end
        end
      end
      CS_ROUND: begin
        w_nxt = (sub == 2'd3) ? perm : upd;
      end
      CS_FINAL: begin
        // Shift down one word and append word fin_r plus its initial value.
        w_nxt = {w_r[0] + init_word(cfg, ctr_r, fin_r), w_r[BLK_WORDS-1:1]};
      end
      default: w_nxt = w_r;
    endcase
  end

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      CS_IDLE:  if (req.start) phase_nxt = CS_ROUND;
      CS_ROUND: if (step_r == LAST_STEP) phase_nxt = CS_FINAL;
      CS_FINAL: if (fin_r == LAST_WORD) phase_nxt = CS_IDLE;
      default:  phase_nxt = CS_IDLE;
    endcase
  end

  // Status outputs; the keystream is read only while the core is idle.
  always_comb begin
    ks_word      = w_r[byte_sel[POS_W-1:2]];
    sts.busy     = (phase_r != CS_IDLE);
    sts.done     = (phase_r == CS_FINAL) && (fin_r == LAST_WORD);
    sts.ks_byte  = ks_word[byte_sel[1:0]*8 +: 8];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= CS_IDLE;
      step_r  <= '0;
      fin_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      if (phase_r == CS_IDLE) begin
        step_r <= '0;
        fin_r  <= '0;
      end else if (phase_r == CS_ROUND) begin
        step_r <= step_r + 1'b1;
      end else begin
        fin_r <= fin_r + 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    w_r <= w_nxt;
    if (phase_r == CS_IDLE && req.start) begin
      ctr_r <= req.counter;
    end
  end

endmodule

>>> src/chacha20_stream_cipher.sv
// ----------------------------------------------------------------------------
// chacha20_stream_cipher
// ChaCha20 (IETF) byte stream cipher with a shared-round block generator.
// ----------------------------------------------------------------------------
// Each input beat carries one byte, which comes back XORed with the next
// keystream byte; encryption and decryption are the same operation. A beat
// with msg_start set restarts at block 0, byte 0. A byte whose 64-byte
// keystream block is already available is accepted, then loaded into the
// output register once that register is free. The first byte of each block
// waits for the block generator, whose single add-xor-rotate unit performs
// one quarter-round step per cycle: a load, the round steps and the final
// addition. Key and nonce registers are written through the cfg_ port; the
// user must write them only while the block is idle (the block itself does
// not enforce this), and they are used from the next block computed.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher import cc20_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  cc20_in_if.sink               in_ch,
  cc20_out_if.source            out_ch
);

  top_state_t        state_r, state_nxt;
  cc20_cfg_t         cfg_r;
  logic [7:0]        data_r;
  logic [POS_W-1:0]  pos_r;
  logic [WORD_W-1:0] ctr_r;
  logic              blk_rdy_r;
  logic              out_valid_r;
  logic [7:0]        out_byte_r;

  logic              in_fire;
  logic              slot_free;
  logic              emit;
  core_req_t         req;
  core_sts_t         sts;

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign slot_free = !out_valid_r || out_ch.ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_ch.msg_start || !blk_rdy_r) ? ST_LOAD : ST_EMIT;
        end
      end
      ST_LOAD: state_nxt = ST_WAIT;
      ST_WAIT: if (sts.done) state_nxt = ST_EMIT;
      ST_EMIT: if (slot_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_ch.ready = (state_r == ST_IDLE);
    req.start   = (state_r == ST_LOAD);
    req.counter = ctr_r;
    emit        = (state_r == ST_EMIT) && slot_free;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;

  cc20_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .req      (req),
    .byte_sel (pos_r),
    .sts      (sts)
  );

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_KEY0:     cfg_r.key[1:0]   <= cfg_wdata;
        REG_KEY1:     cfg_r.key[3:2]   <= cfg_wdata;
        REG_KEY2:     cfg_r.key[5:4]   <= cfg_wdata;
        REG_KEY3:     cfg_r.key[7:6]   <= cfg_wdata;
        REG_NONCE_LO: cfg_r.nonce[1:0] <= cfg_wdata;
        REG_NONCE_HI: cfg_r.nonce[2]   <= cfg_wdata[WORD_W-1:0];
        default:      cfg_r <= cfg_r;
      endcase
    end
  end

  // Stream position, block counter and keystream validity.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      ctr_r       <= '0;
      blk_rdy_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_fire && in_ch.msg_start) begin
        pos_r     <= '0;
        ctr_r     <= '0;
        blk_rdy_r <= 1'b0;
      end
      if (sts.done) begin
        blk_rdy_r <= 1'b1;
      end
      if (emit) begin
        pos_r <= pos_r + 1'b1;
        if (pos_r == LAST_POS) begin
          ctr_r     <= ctr_r + 1'b1;
          blk_rdy_r <= 1'b0;
        end
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Beat payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      data_r <= in_ch.in_byte;
    end
    if (emit) begin
      out_byte_r <= data_r ^ sts.ks_byte;
    end
  end

  // The generator runs only while the controller waits for it.
  a_idle_core: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !sts.busy)
    else $error("block core busy while the controller is idle");

  a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sts.done |-> state_r == ST_WAIT)
    else $error("block completion outside the wait state");

  a_emit_ready: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> blk_rdy_r)
    else $error("byte emitted without a valid keystream block");

  a_block_end: assert property (@(posedge clk) disable iff (!rst_n)
    emit && pos_r == LAST_POS |=> !blk_rdy_r)
    else $error("keystream block still marked valid after its last byte");

endmodule
